FILE: sv/i2da_pkg.sv
// Package for the decimal ASCII converter: widths, character codes and sequencer states.
package i2da_pkg;

    localparam int VALUE_W       = 64;
    localparam int SIZE_W        = 6;
    localparam int CHAR_W        = 8;
    localparam int BCD_DIGITS    = 20;
    localparam int BCD_W         = 4 * BCD_DIGITS;
    localparam int DIGIT_IDX_W   = $clog2(BCD_DIGITS);
    localparam int STEP_BITS     = 4;
    localparam int CONV_CYCLES   = VALUE_W / STEP_BITS;
    localparam int CONV_CNT_W    = $clog2(CONV_CYCLES);
    localparam int MAX_DIGITS_DEF = 20;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_bcd_ctrl;

endpackage

FILE: sv/integer_to_decimal_ascii.sv
// Top level of the decimal ASCII converter: command sequencer and character output.
// A conversion is taken when start is high and busy is low. A buffer size of zero or one
// gives its single result in the cycle after start and leaves busy low. Otherwise the
// magnitude goes through the BCD unit, four bits a cycle over the 64-bit magnitude, the
// COUNT state finds the digit count, and then one character is strobed per cycle. Each
// character is on the outputs for exactly one cycle with o_strobe high and must be taken
// then.
module integer_to_decimal_ascii #(
    parameter int MAX_DIGITS = i2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [i2da_pkg::VALUE_W-1:0]  i_value,
    input  logic [i2da_pkg::SIZE_W-1:0]   i_buffer_size,
    output logic                          o_strobe,
    output logic [i2da_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last,
    output logic                          o_error
);
    import i2da_pkg::*;

    localparam logic [SIZE_W-1:0] DIGIT_CAP = SIZE_W'(MAX_DIGITS);

    t_state             r_state;
    t_state             n_state;
    logic [CONV_CNT_W-1:0] r_cnt;
    logic [CONV_CNT_W-1:0] n_cnt;
    logic               r_neg;
    logic               n_neg;
    logic               r_sign;
    logic               n_sign;
    logic [SIZE_W-1:0]  r_room;
    logic [SIZE_W-1:0]  n_room;
    logic [SIZE_W-1:0]  r_pos;
    logic [SIZE_W-1:0]  n_pos;
    logic               r_strobe;
    logic               n_strobe;
    logic [CHAR_W-1:0]  r_char;
    logic [CHAR_W-1:0]  n_char;
    logic               r_last;
    logic               n_last;
    logic               r_error;
    logic               n_error;

    t_bcd_ctrl          w_ctrl;
    logic [BCD_W-1:0]   w_bcd;
    logic [VALUE_W-1:0] w_mag;
    logic [31:0]        w_low;
    logic [31:0]        w_mag32;
    logic               w_neg;
    logic               w_accept;
    logic [SIZE_W-1:0]  w_ndig;
    logic [3:0]         w_digit;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    assign w_low   = i_value[31:0];
    assign w_neg   = i_cmd && w_low[31];
    assign w_mag32 = w_neg ? (32'd0 - w_low) : w_low;
    assign w_mag   = i_cmd ? {32'd0, w_mag32} : i_value;

    assign w_digit = w_bcd[r_pos[DIGIT_IDX_W-1:0]*4 +: 4];

    always_comb begin
        w_ndig = SIZE_W'(1);
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (w_bcd[d*4 +: 4] != 4'd0) begin
                w_ndig = SIZE_W'(d + 1);
            end
        end
        if (w_ndig > DIGIT_CAP) begin
            w_ndig = DIGIT_CAP;
        end
        if (w_ndig > r_room) begin
            w_ndig = r_room;
        end
    end

    i2da_bcd_unit u_bcd (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_mag  (w_mag),
        .o_bcd  (w_bcd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_buffer_size > SIZE_W'(1))) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_cnt == CONV_CNT_W'(CONV_CYCLES - 1)) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_sign && (r_pos == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctrl   = '0;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_sign   = r_sign;
        n_room   = r_room;
        n_pos    = r_pos;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        n_error  = r_error;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_buffer_size == '0) begin
                        n_strobe = 1'b1;
                        n_char   = CHAR_NONE;
                        n_last   = 1'b1;
                        n_error  = 1'b1;
                    end else if (i_buffer_size == SIZE_W'(1)) begin
                        n_strobe = 1'b1;
                        n_char   = CHAR_NONE;
                        n_last   = 1'b1;
                        n_error  = 1'b0;
                    end else begin
                        w_ctrl.load = 1'b1;
                        n_cnt       = '0;
                        n_neg       = w_neg;
                        n_room      = i_buffer_size - SIZE_W'(1);
                    end
                end
            end
            ST_CONV: begin
                w_ctrl.step = 1'b1;
                n_cnt       = r_cnt + CONV_CNT_W'(1);
            end
            ST_COUNT: begin
                n_pos  = w_ndig - SIZE_W'(1);
                n_sign = r_neg && (w_ndig < r_room);
            end
            ST_EMIT: begin
                n_strobe = 1'b1;
                n_error  = 1'b0;
                if (r_sign) begin
                    n_char = CHAR_MINUS;
                    n_last = 1'b0;
                    n_sign = 1'b0;
                end else begin
                    n_char = CHAR_ZERO + {4'd0, w_digit};
                    n_last = (r_pos == '0);
                    n_pos  = r_pos - SIZE_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_neg   <= n_neg;
        r_sign  <= n_sign;
        r_room  <= n_room;
        r_pos   <= n_pos;
        r_char  <= n_char;
        r_last  <= n_last;
        r_error <= n_error;
    end

    assign o_strobe    = r_strobe;
    assign o_char_code = r_char;
    assign o_last      = r_last;
    assign o_error     = r_error;

    a_zero_size_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_buffer_size == '0)) |=> (o_strobe && o_error && o_last))
        else $error("zero buffer size did not give an error result");

    a_quiet_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !n_strobe)
        else $error("character strobed during conversion");

    a_emit_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && !r_sign && (r_pos == '0)) |=> (!busy && o_strobe && o_last))
        else $error("final character did not end the transaction");

    a_sign_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && r_sign) |=> (o_char_code == CHAR_MINUS && !o_last))
        else $error("minus sign not emitted first");

endmodule

FILE: sv/i2da_bcd_unit.sv
// Shift-and-add-3 unit: binary magnitude to BCD digits, four bits a cycle while step is high.
module i2da_bcd_unit (
    input  logic                          i_clk,
    input  i2da_pkg::t_bcd_ctrl           i_ctrl,
    input  logic [i2da_pkg::VALUE_W-1:0]  i_mag,
    output logic [i2da_pkg::BCD_W-1:0]    o_bcd
);
    import i2da_pkg::*;

    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   n_bcd;
    logic [VALUE_W-1:0] r_bin;
    logic [VALUE_W-1:0] n_bin;
    logic [BCD_W-1:0]   w_bcd;
    logic [VALUE_W-1:0] w_bin;

    always_comb begin
        w_bcd = r_bcd;
        w_bin = r_bin;
        for (int s = 0; s < STEP_BITS; s++) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (w_bcd[d*4 +: 4] >= 4'd5) begin
                    w_bcd[d*4 +: 4] = w_bcd[d*4 +: 4] + 4'd3;
                end
            end
            {w_bcd, w_bin} = {w_bcd[BCD_W-2:0], w_bin, 1'b0};
        end
    end

    always_comb begin
        n_bcd = r_bcd;
        n_bin = r_bin;
        if (i_ctrl.load) begin
            n_bcd = '0;
            n_bin = i_mag;
        end else if (i_ctrl.step) begin
            n_bcd = w_bcd;
            n_bin = w_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        r_bin <= n_bin;
    end

    assign o_bcd = r_bcd;

endmodule

FILE: bench/i2da_char_checker.sv
// Checker for the decimal ASCII converter: predicts each character transaction and compares it.
module i2da_char_checker #(
    parameter int MAX_DIGITS = i2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          i_cmd,
    input  logic [i2da_pkg::VALUE_W-1:0]  i_value,
    input  logic [i2da_pkg::SIZE_W-1:0]   i_buffer_size,
    input  logic                          o_strobe,
    input  logic [i2da_pkg::CHAR_W-1:0]   o_char_code,
    input  logic                          o_last,
    input  logic                          o_error,
    output int                            o_mismatches,
    output int                            o_chars_pending
);
    import i2da_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              error;
    } t_char_result;

    t_char_result expected_chars[$];

    function automatic void predict_characters(input logic cmd,
                                               input logic [VALUE_W-1:0] value,
                                               input logic [SIZE_W-1:0] size);
        logic [CHAR_W-1:0] text[$];
        logic [VALUE_W-1:0] magnitude;
        logic [31:0] low_word;
        logic negative;
        int room;
        if (size == 0) begin
            expected_chars.push_back(t_char_result'{CHAR_NONE, 1'b1, 1'b1});
            return;
        end
        negative = 1'b0;
        if (cmd) begin
            low_word = value[31:0];
            negative = low_word[31];
            if (negative)
                low_word = 32'd0 - low_word;
            magnitude = {32'd0, low_word};
        end else begin
            magnitude = value;
        end
        room = int'(size) - 1;
        if (magnitude == 0) begin
            if (room >= 1)
                text.push_front(CHAR_ZERO);
        end else begin
            while (magnitude != 0 && text.size() < room && text.size() < MAX_DIGITS) begin
                text.push_front(CHAR_ZERO + CHAR_W'(magnitude % 10));
                magnitude = magnitude / 10;
            end
            if (negative && text.size() < room)
                text.push_front(CHAR_MINUS);
        end
        if (text.size() == 0) begin
            expected_chars.push_back(t_char_result'{CHAR_NONE, 1'b1, 1'b0});
            return;
        end
        foreach (text[k])
            expected_chars.push_back(t_char_result'{text[k], k == text.size() - 1, 1'b0});
    endfunction

    always @(posedge i_clk) begin
        t_char_result want;
        if (!i_rst_n) begin
            expected_chars.delete();
            o_mismatches = 0;
        end else begin
            if (o_strobe) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character: expected none, actual %h last %b error %b",
                             $time, o_char_code, o_last, o_error);
                    o_mismatches = o_mismatches + 1;
                end else begin
                    want = expected_chars.pop_front();
                    if (o_char_code !== want.char_code) begin
                        $display("%0t: char_code mismatch: expected %h, actual %h",
                                 $time, want.char_code, o_char_code);
                        o_mismatches = o_mismatches + 1;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.last, o_last);
                        o_mismatches = o_mismatches + 1;
                    end
                    if (o_error !== want.error) begin
                        $display("%0t: error mismatch: expected %b, actual %b",
                                 $time, want.error, o_error);
                        o_mismatches = o_mismatches + 1;
                    end
                end
            end
            if (start && !busy)
                predict_characters(i_cmd, i_value, i_buffer_size);
        end
        o_chars_pending = expected_chars.size();
    end

endmodule

FILE: bench/tb.sv
// Testbench top for the decimal ASCII converter: drives conversions and reports the verdict.
module tb;
    import i2da_pkg::*;

    localparam int CLK_PERIOD = 12;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cmd;
    logic [VALUE_W-1:0] i_value;
    logic [SIZE_W-1:0]  i_buffer_size;
    logic               o_strobe;
    logic [CHAR_W-1:0]  o_char_code;
    logic               o_last;
    logic               o_error;
    int                 mismatches;
    int                 chars_pending;
    int                 sender_idle_pct;

    integer_to_decimal_ascii #(.MAX_DIGITS(MAX_DIGITS_DEF)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .i_buffer_size (i_buffer_size),
        .o_strobe      (o_strobe),
        .o_char_code   (o_char_code),
        .o_last        (o_last),
        .o_error       (o_error)
    );

    i2da_char_checker #(.MAX_DIGITS(MAX_DIGITS_DEF)) u_char_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_value         (i_value),
        .i_buffer_size   (i_buffer_size),
        .o_strobe        (o_strobe),
        .o_char_code     (o_char_code),
        .o_last          (o_last),
        .o_error         (o_error),
        .o_mismatches    (mismatches),
        .o_chars_pending (chars_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("integer_to_decimal_ascii test failed");
        $finish;
    end

    task automatic send_conversion(input logic cmd, input logic [VALUE_W-1:0] value,
                                   input logic [SIZE_W-1:0] size);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_value       <= value;
        i_buffer_size <= size;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        while (chars_pending != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] power;
        power = 64'd1;
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return {$urandom, $urandom} >> $urandom_range(63);
            2: return 64'($urandom_range(20));
            3: return {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(1000))};
            4: return {$urandom, 32'h8000_0000 + 32'($urandom_range(3))};
            default: begin
                repeat ($urandom_range(19)) power = power * 10;
                return power + 64'($urandom_range(2)) - 64'd1;
            end
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        case ($urandom_range(9))
            0: return SIZE_W'($urandom_range(1));
            1: return SIZE_W'($urandom_range(32, 22));
            2: return SIZE_W'($urandom_range(63, 33));
            default: return SIZE_W'($urandom_range(21, 2));
        endcase
    endfunction

    task automatic send_random_batch(input int count);
        repeat (count) begin
            send_conversion($urandom_range(1), random_value(), random_size());
            if ($urandom_range(39) == 0)
                hold_until_drained();
        end
        hold_until_drained();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_cmd           = 1'b0;
        i_value         = '0;
        i_buffer_size   = '0;
        sender_idle_pct = 15;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_conversion(1'b0, 64'h0123_4567_89AB_CDEF, 6'd0);
        send_conversion(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
        send_conversion(1'b0, 64'd0, 6'd1);
        send_conversion(1'b0, 64'd123, 6'd1);
        send_conversion(1'b1, 64'hFFFF_FFFF_FFFF_FFFB, 6'd1);
        send_conversion(1'b0, 64'd0, 6'd2);
        send_conversion(1'b1, 64'd0, 6'd32);
        send_conversion(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 6'd32);
        send_conversion(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        send_conversion(1'b0, 64'h8000_0000_0000_0000, 6'd21);
        send_conversion(1'b0, 64'd12345, 6'd3);
        send_conversion(1'b0, 64'd10_000_000_000_000_000_000, 6'd20);
        send_conversion(1'b1, 64'h0000_0000_8000_0000, 6'd32);
        send_conversion(1'b1, 64'h0000_0000_8000_0000, 6'd12);
        send_conversion(1'b1, 64'h0000_0000_8000_0000, 6'd11);
        send_conversion(1'b0, 64'h0000_0000_8000_0000, 6'd32);
        send_conversion(1'b1, 64'h0000_0000_7FFF_FFFF, 6'd32);
        send_conversion(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 6'd3);
        send_conversion(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 6'd2);
        send_conversion(1'b1, 64'hFFFF_FFFF_FFFF_FFFB, 6'd2);
        send_conversion(1'b1, 64'hDEAD_BEEF_0000_0005, 6'd32);
        send_conversion(1'b1, 64'h1234_5678_FFFF_D8F1, 6'd4);
        hold_until_drained();

        send_random_batch(160);
        sender_idle_pct = 57;
        send_random_batch(150);
        sender_idle_pct = 0;
        send_random_batch(150);

        repeat (40) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("integer_to_decimal_ascii test passed");
        end else begin
            $display("integer_to_decimal_ascii test failed");
        end
        $finish;
    end

endmodule
